[hw/rtl/load_cell_consumption_tracker_macros.svh]
// ----------------------------------------------------------------------------
// Load cell consumption tracker assertion macros
// Clocked assertion shorthands with synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef LOAD_CELL_CONSUMPTION_TRACKER_MACROS_SVH
`define LOAD_CELL_CONSUMPTION_TRACKER_MACROS_SVH

// same-cycle implication
`define LCCT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LCCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lcct_pkg.sv]
// ----------------------------------------------------------------------------
// Load cell consumption tracker package
// Request and result types, configuration types and mode codes.
// ----------------------------------------------------------------------------
package lcct_pkg;

  localparam int WeightW = 19;
  localparam int LimitW  = 18;
  localparam int DeltaW  = 17;
  localparam int ModeW   = 3;
  localparam int CfgIdxW = 2;

  localparam logic [ModeW-1:0] MODE_UNAVAILABLE = 3'd0;
  localparam logic [ModeW-1:0] MODE_EMPTY       = 3'd1;
  localparam logic [ModeW-1:0] MODE_PRESENT     = 3'd2;
  localparam logic [ModeW-1:0] MODE_CONSUMING   = 3'd3;
  localparam logic [ModeW-1:0] MODE_LEFTOVER    = 3'd4;
  localparam logic [ModeW-1:0] MODE_REMOVED     = 3'd5;

  localparam logic [CfgIdxW-1:0] REG_EMPTY_LIMIT   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_REMOVED_LIMIT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_CONSUME_DROP  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_REFILL_RISE   = 2'd3;

  localparam logic signed [LimitW-1:0] EMPTY_LIMIT_RST   = 18'sd30;
  localparam logic signed [LimitW-1:0] REMOVED_LIMIT_RST = -18'sd100;
  localparam logic [DeltaW-1:0]        CONSUME_DROP_RST  = 17'd20;
  localparam logic [DeltaW-1:0]        REFILL_RISE_RST   = 17'd50;

  typedef struct packed {
    logic signed [WeightW-1:0] weight_dg;
    logic                      is_stable;
  } in_item_t;

  typedef struct packed {
    logic [ModeW-1:0] current_state;
    logic [ModeW-1:0] previous_state;
    logic             state_changed;
  } out_item_t;

  typedef struct packed {
    logic signed [LimitW-1:0] empty_limit;
    logic signed [LimitW-1:0] removed_limit;
    logic [DeltaW-1:0]        consume_drop;
    logic [DeltaW-1:0]        refill_rise;
  } cfg_t;

endpackage

[hw/rtl/lcct_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Load cell consumption tracker configuration registers
// Holds the weight limits and drop/rise thresholds written over the cfg port.
// ----------------------------------------------------------------------------
module lcct_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lcct_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [lcct_pkg::LimitW-1:0]  cfg_data,
  output lcct_pkg::cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.empty_limit   <= lcct_pkg::EMPTY_LIMIT_RST;
      cfg.removed_limit <= lcct_pkg::REMOVED_LIMIT_RST;
      cfg.consume_drop  <= lcct_pkg::CONSUME_DROP_RST;
      cfg.refill_rise   <= lcct_pkg::REFILL_RISE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lcct_pkg::REG_EMPTY_LIMIT:   cfg.empty_limit   <= cfg_data;
        lcct_pkg::REG_REMOVED_LIMIT: cfg.removed_limit <= cfg_data;
        lcct_pkg::REG_CONSUME_DROP:  cfg.consume_drop  <= cfg_data[lcct_pkg::DeltaW-1:0];
        lcct_pkg::REG_REFILL_RISE:   cfg.refill_rise   <= cfg_data[lcct_pkg::DeltaW-1:0];
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/lcct_tracker.sv]
// ----------------------------------------------------------------------------
// Load cell consumption tracker mode logic
// Classifies each request against the limits and the reference weight and
// advances the container mode on each step and updates the reference on captures.
// ----------------------------------------------------------------------------
`include "load_cell_consumption_tracker_macros.svh"

module lcct_tracker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  lcct_pkg::in_item_t   sample,
  input  lcct_pkg::cfg_t       cfg,
  output lcct_pkg::out_item_t  res
);

  logic [lcct_pkg::ModeW-1:0]          mode;
  logic [lcct_pkg::ModeW-1:0]          mode_next;
  logic signed [lcct_pkg::WeightW-1:0] reference_weight;
  logic                                capture;

  logic signed [lcct_pkg::WeightW-1:0] w;
  logic signed [lcct_pkg::WeightW-1:0] removed_ext;
  logic signed [lcct_pkg::WeightW-1:0] empty_ext;
  logic signed [lcct_pkg::WeightW:0]   w_wide;
  logic signed [lcct_pkg::WeightW:0]   ref_low;
  logic signed [lcct_pkg::WeightW:0]   ref_high;
  logic                                stable;
  logic                                gone;
  logic                                low;
  logic                                dropped;
  logic                                risen;

  assign w           = sample.weight_dg;
  assign stable      = sample.is_stable;
  assign removed_ext = {cfg.removed_limit[lcct_pkg::LimitW-1], cfg.removed_limit};
  assign empty_ext   = {cfg.empty_limit[lcct_pkg::LimitW-1], cfg.empty_limit};
  assign w_wide      = {w[lcct_pkg::WeightW-1], w};
  assign ref_low     = {reference_weight[lcct_pkg::WeightW-1], reference_weight}
                       - {3'b000, cfg.consume_drop};
  assign ref_high    = {reference_weight[lcct_pkg::WeightW-1], reference_weight}
                       + {3'b000, cfg.refill_rise};
  assign gone        = w <= removed_ext;
  assign low         = w <= empty_ext;
  assign dropped     = w_wide < ref_low;
  assign risen       = w_wide > ref_high;

  always_comb begin
    mode_next = mode;
    capture   = 1'b0;
    case (mode)
      lcct_pkg::MODE_UNAVAILABLE: begin
        if (stable) begin
          if (gone) begin
            mode_next = lcct_pkg::MODE_REMOVED;
          end else if (low) begin
            mode_next = lcct_pkg::MODE_EMPTY;
          end else begin
            mode_next = lcct_pkg::MODE_PRESENT;
            capture   = 1'b1;
          end
        end
      end
      lcct_pkg::MODE_EMPTY: begin
        if (gone) begin
          mode_next = lcct_pkg::MODE_REMOVED;
        end else if (stable && !low) begin
          mode_next = lcct_pkg::MODE_PRESENT;
          capture   = 1'b1;
        end
      end
      lcct_pkg::MODE_PRESENT, lcct_pkg::MODE_LEFTOVER: begin
        if (gone) begin
          mode_next = lcct_pkg::MODE_REMOVED;
        end else if (stable && low) begin
          mode_next = lcct_pkg::MODE_EMPTY;
        end else if (!stable && dropped) begin
          mode_next = lcct_pkg::MODE_CONSUMING;
        end else if (stable && risen) begin
          mode_next = lcct_pkg::MODE_PRESENT;
          capture   = 1'b1;
        end
      end
      lcct_pkg::MODE_CONSUMING: begin
        if (gone) begin
          mode_next = lcct_pkg::MODE_REMOVED;
        end else if (stable) begin
          if (low) begin
            mode_next = lcct_pkg::MODE_EMPTY;
          end else begin
            mode_next = lcct_pkg::MODE_LEFTOVER;
            capture   = 1'b1;
          end
        end
      end
      lcct_pkg::MODE_REMOVED: begin
        if (stable && !gone) begin
          if (low) begin
            mode_next = lcct_pkg::MODE_EMPTY;
          end else begin
            mode_next = lcct_pkg::MODE_PRESENT;
            capture   = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= lcct_pkg::MODE_UNAVAILABLE;
      reference_weight <= '0;
    end else if (step) begin
      mode <= mode_next;
      if (capture) begin
        reference_weight <= w;
      end
    end
  end

  assign res.current_state  = mode_next;
  assign res.previous_state = mode;
  assign res.state_changed  = mode_next != mode;

  `LCCT_ASSERT_NEXT(a_mode_follows_result, clk, rst, step,
                    mode == $past(res.current_state), "mode does not follow result")
  `LCCT_ASSERT_NEXT(a_reference_holds_idle, clk, rst, !step,
                    $stable(reference_weight), "reference moved without a step")
  `LCCT_ASSERT_NOW(a_removed_waits_stable, clk, rst,
                   step && mode == lcct_pkg::MODE_REMOVED && !stable,
                   !res.state_changed, "removed mode left on unstable sample")

endmodule

[hw/rtl/load_cell_consumption_tracker.sv]
// ----------------------------------------------------------------------------
// Load cell consumption tracker
// Tracks container mode and reference weight from a stream of weight requests.
// ----------------------------------------------------------------------------
// Accepts one request per clock while no held result stalls the output, and
// returns exactly one result per request, in order. A request is held in the
// input register, where the mode logic classifies it, then moves to the
// result register as mode and reference update: out_valid rises when it
// enters the result register, and a request waits in the input register for
// as long as a held result stalls the output. Throughput is one request per
// cycle while the output does not stall. Configuration writes take effect at
// the next edge and belong only to idle periods.
module load_cell_consumption_tracker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  lcct_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output lcct_pkg::out_item_t          out_data,
  input  logic                         cfg_we,
  input  logic [lcct_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [lcct_pkg::LimitW-1:0]  cfg_data
);

  lcct_pkg::cfg_t      cfg;
  lcct_pkg::in_item_t  s0_data;
  lcct_pkg::out_item_t res;
  logic                s0_valid;
  logic                s1_load;

  assign s1_load  = s0_valid && (!out_valid || out_ready);
  assign in_ready = !s0_valid || s1_load;

  lcct_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lcct_tracker u_trk (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_load),
    .sample (s0_data),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_data <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      out_data <= res;
    end
  end

endmodule
